[rtl/gb5_pkg.sv]
// Shared types, constants and kernel weights for the 5x5 Gaussian blur.
// Used by the line-store RAM and the top level; depends on nothing else.
package gb5_pkg;

    // Geometry of the kernel and of the line history.
    localparam int KERNEL_SIZE       = 5;
    localparam int HIST_ROWS         = 4;
    localparam int SLOT_W            = 2;
    localparam int CHAN_W            = 8;
    localparam int NUM_CHAN          = 3;
    localparam int PIXEL_W           = NUM_CHAN * CHAN_W;
    localparam int LINE_WORD_W       = HIST_ROWS * PIXEL_W;
    localparam int DEFAULT_MAX_WIDTH = 1024;

    // Channel positions inside a packed pixel (red in the top byte).
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    // Configuration registers.
    localparam int IMAGE_WIDTH_W  = 11;
    localparam int IMAGE_HEIGHT_W = 13;
    localparam int ROW_W          = 12;
    localparam int MAX_HEIGHT     = 4096;
    localparam int WIDTH_RESET    = 640;
    localparam int HEIGHT_RESET   = 480;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;
    localparam int REG_IDX_W      = 1;

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Arithmetic widths. Division by the kernel sum is a multiply by
    // ceil(2^18 / 27) and a shift, exact for every sum below 6886.
    localparam int KERNEL_SUM  = 27;
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_MUL   = (1 << RECIP_SHIFT) / KERNEL_SUM + 1;
    localparam int RECIP_W     = 14;
    localparam int ROWSUM_W    = 12;
    localparam int SUM_W       = 13;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    typedef logic [2:0] weight_t;

    localparam weight_t KERNEL_WEIGHTS [KERNEL_SIZE][KERNEL_SIZE] = '{
        '{3'd0, 3'd0, 3'd1, 3'd0, 3'd0},
        '{3'd0, 3'd1, 3'd3, 3'd1, 3'd0},
        '{3'd1, 3'd3, 3'd7, 3'd3, 3'd1},
        '{3'd0, 3'd1, 3'd3, 3'd1, 3'd0},
        '{3'd0, 3'd0, 3'd1, 3'd0, 3'd0}
    };

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              last_pixel;
    } pixel_out_t;

endpackage

[rtl/gaussian_blur_5x5.sv]
// Streaming 5x5 Gaussian blur: line-store RAM, 5x5 window, kernel pipeline, APB registers.
// A result reaches m_* via the p1, window, row-sum, sum, product and output registers.
// Throughput: one pixel per cycle while s_ready is high, set by the line-store read/write.
// While a result waits, the pipeline keeps moving until a second result fills the skid
// stage; only then does s_ready drop, and it rises again the cycle after the output moves.
// Reset (aresetn low, synchronous): counters, valids, width 640 and height 480 restored.
// The line store and window are not cleared; no clearing pass, s_ready high out of reset.
module gaussian_blur_5x5
    import gb5_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Pixel input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pixel_in_t             s_pixel,
    // Result output
    output logic                  m_valid,
    input  logic                  m_ready,
    output pixel_out_t            m_pixel,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int EWM = $clog2(MAX_WIDTH + 1);
    localparam int EW  = (EWM > IMAGE_WIDTH_W) ? EWM : IMAGE_WIDTH_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [IMAGE_WIDTH_W-1:0]  image_width_reg;
    logic [IMAGE_HEIGHT_W-1:0] image_height_reg;
    logic                      cfg_wr;
    logic [REG_IDX_W-1:0]      cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[APB_ADDR_W-1 -: REG_IDX_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IMAGE_WIDTH_W'(WIDTH_RESET);
            image_height_reg <= IMAGE_HEIGHT_W'(HEIGHT_RESET);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[IMAGE_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[IMAGE_HEIGHT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height_reg);
        endcase
    end

    // Effective frame size after clamping to the supported range.
    logic [EW-1:0]             width_ext;
    logic [EW-1:0]             eff_w;
    logic [IMAGE_HEIGHT_W-1:0] eff_h;

    assign width_ext = EW'(image_width_reg);

    always_comb begin
        if (width_ext < EW'(KERNEL_SIZE)) begin
            eff_w = EW'(KERNEL_SIZE);
        end else if (width_ext > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = width_ext;
        end
        if (image_height_reg < IMAGE_HEIGHT_W'(KERNEL_SIZE)) begin
            eff_h = IMAGE_HEIGHT_W'(KERNEL_SIZE);
        end else if (image_height_reg > IMAGE_HEIGHT_W'(MAX_HEIGHT)) begin
            eff_h = IMAGE_HEIGHT_W'(MAX_HEIGHT);
        end else begin
            eff_h = image_height_reg;
        end
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipeline moves whenever the skid is empty.
    // ------------------------------------------------------------------
    logic skid_valid_reg;
    logic en;
    logic s_accept;

    assign en       = ~skid_valid_reg;
    assign s_ready  = en;
    assign s_accept = s_valid & en;

    // ------------------------------------------------------------------
    // Raster position of the next pixel
    // ------------------------------------------------------------------
    logic [CW-1:0]             col_reg;
    logic [ROW_W-1:0]          row_reg;
    logic [EW-1:0]             col_inc;
    logic [IMAGE_HEIGHT_W-1:0] row_inc;
    logic                      col_end;
    logic                      row_end;
    logic                      pos_prod;
    logic                      pos_last;

    assign col_inc  = EW'(col_reg) + EW'(1);
    assign row_inc  = IMAGE_HEIGHT_W'(row_reg) + IMAGE_HEIGHT_W'(1);
    assign col_end  = col_inc >= eff_w;
    assign row_end  = row_inc >= eff_h;
    assign pos_prod = (row_reg >= ROW_W'(KERNEL_SIZE - 1)) && (col_reg >= CW'(KERNEL_SIZE - 1));
    assign pos_last = row_end && col_end;

    // Any register write restarts the frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cfg_wr) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            if (col_end) begin
                col_reg <= '0;
                row_reg <= row_end ? '0 : ROW_W'(row_inc);
            end else begin
                col_reg <= CW'(col_inc);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: accepted pixel, line-store read in flight
    // ------------------------------------------------------------------
    logic               p1_valid_reg;
    logic [PIXEL_W-1:0] p1_px_reg;
    logic [CW-1:0]      p1_col_reg;
    logic [SLOT_W-1:0]  p1_slot_reg;
    logic               p1_prod_reg;
    logic               p1_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_px_reg   <= PIXEL_W'(s_pixel);
            p1_col_reg  <= col_reg;
            p1_slot_reg <= row_reg[SLOT_W-1:0];
            p1_prod_reg <= pos_prod;
            p1_last_reg <= pos_last;
        end
    end

    // Line store: one word per column holds the four history rows. The word
    // is read on acceptance and written back, with this row's slot replaced,
    // on the next pipeline move. Reads and writes advance together and the
    // same column is read again only a full row (at least five pixels) later,
    // so no forwarding is needed.
    logic                   p1_consume;
    logic [LINE_WORD_W-1:0] line_rdata;
    logic [LINE_WORD_W-1:0] line_wdata;

    assign p1_consume = en & p1_valid_reg;

    always_comb begin
        for (int s = 0; s < HIST_ROWS; s++) begin
            if (p1_slot_reg == SLOT_W'(s)) begin
                line_wdata[s*PIXEL_W +: PIXEL_W] = p1_px_reg;
            end else begin
                line_wdata[s*PIXEL_W +: PIXEL_W] = line_rdata[s*PIXEL_W +: PIXEL_W];
            end
        end
    end

    gb5_ram #(
        .WIDTH (LINE_WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (p1_consume),
        .waddr (p1_col_reg),
        .wdata (line_wdata),
        .re    (s_accept),
        .raddr (col_reg),
        .rdata (line_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 2: 5x5 window, oldest row at the top
    // ------------------------------------------------------------------
    logic [PIXEL_W-1:0] win_reg [KERNEL_SIZE][KERNEL_SIZE];
    logic               w_valid_reg;
    logic               w_last_reg;
    logic [SLOT_W-1:0]  win_slot [HIST_ROWS];

    always_comb begin
        for (int r = 0; r < HIST_ROWS; r++) begin
            win_slot[r] = p1_slot_reg + SLOT_W'(r);
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_consume) begin
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
                    win_reg[r][c] <= win_reg[r][c+1];
                end
            end
            for (int r = 0; r < HIST_ROWS; r++) begin
                win_reg[r][KERNEL_SIZE-1] <= line_rdata[win_slot[r]*PIXEL_W +: PIXEL_W];
            end
            win_reg[KERNEL_SIZE-1][KERNEL_SIZE-1] <= p1_px_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg <= 1'b0;
        end else if (en) begin
            w_valid_reg <= p1_valid_reg & p1_prod_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w_last_reg <= p1_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: weighted row sums per channel
    // ------------------------------------------------------------------
    logic [ROWSUM_W-1:0] rowsum_next [NUM_CHAN][KERNEL_SIZE];
    logic [ROWSUM_W-1:0] rowsum_reg  [NUM_CHAN][KERNEL_SIZE];
    logic                s3_valid_reg;
    logic                s3_last_reg;

    always_comb begin
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                rowsum_next[ch][r] = '0;
                for (int c = 0; c < KERNEL_SIZE; c++) begin
                    rowsum_next[ch][r] = rowsum_next[ch][r]
                        + ROWSUM_W'(KERNEL_WEIGHTS[r][c])
                        * ROWSUM_W'(win_reg[r][c][ch*CHAN_W +: CHAN_W]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rowsum_reg  <= rowsum_next;
            s3_last_reg <= w_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: full kernel sum per channel
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] sum_next [NUM_CHAN];
    logic [SUM_W-1:0] sum_reg  [NUM_CHAN];
    logic             s4_valid_reg;
    logic             s4_last_reg;

    always_comb begin
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            sum_next[ch] = '0;
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                sum_next[ch] = sum_next[ch] + SUM_W'(rowsum_reg[ch][r]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg     <= sum_next;
            s4_last_reg <= s3_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: multiply by the reciprocal of the kernel sum
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] prod_reg [NUM_CHAN];
    logic              s5_valid_reg;
    logic              s5_last_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int ch = 0; ch < NUM_CHAN; ch++) begin
                prod_reg[ch] <= PROD_W'(sum_reg[ch]) * PROD_W'(RECIP_MUL);
            end
            s5_last_reg <= s4_last_reg;
        end
    end

    // Valid chain for stages 3 to 5.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg <= w_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Quotient and clamp to the channel range.
    logic [QUOT_W-1:0] quot [NUM_CHAN];
    logic [CHAN_W-1:0] chan_res [NUM_CHAN];
    pixel_out_t        push_pixel;
    logic              push;

    always_comb begin
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            quot[ch] = prod_reg[ch][PROD_W-1:RECIP_SHIFT];
            if (quot[ch] > QUOT_W'({CHAN_W{1'b1}})) begin
                chan_res[ch] = {CHAN_W{1'b1}};
            end else begin
                chan_res[ch] = quot[ch][CHAN_W-1:0];
            end
        end
    end

    assign push_pixel.red_out    = chan_res[CH_RED];
    assign push_pixel.green_out  = chan_res[CH_GREEN];
    assign push_pixel.blue_out   = chan_res[CH_BLUE];
    assign push_pixel.last_pixel = s5_last_reg;
    assign push                  = en & s5_valid_reg;

    // ------------------------------------------------------------------
    // Output register with skid stage
    // ------------------------------------------------------------------
    logic       out_valid_reg;
    pixel_out_t out_pixel_reg;
    pixel_out_t skid_pixel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_pixel_reg <= skid_pixel_reg;
            end else if (push) begin
                out_pixel_reg <= push_pixel;
            end
        end else if (push) begin
            skid_pixel_reg <= push_pixel;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_pixel = out_pixel_reg;

`ifndef NO_ASSERTIONS
    // The skid stage only fills behind a waiting result.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds an item while the output register is empty");

    // The end-of-frame pixel always lies in the interior.
    a_last_is_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && p1_last_reg |-> p1_prod_reg)
        else $error("last pixel marked on a border position");

    // An interior pixel leaving stage 1 yields a valid window.
    a_window_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_consume && p1_prod_reg |=> w_valid_reg)
        else $error("interior pixel lost between stage 1 and the window");

    // The reciprocal multiply never leaves the channel range.
    a_quot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s5_valid_reg |-> (quot[0] <= QUOT_W'({CHAN_W{1'b1}}))
                      && (quot[1] <= QUOT_W'({CHAN_W{1'b1}}))
                      && (quot[2] <= QUOT_W'({CHAN_W{1'b1}})))
        else $error("blurred channel exceeds the channel range");
`endif

endmodule

[rtl/gb5_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Defaults come from gb5_pkg; the storage itself depends on nothing else.
module gb5_ram
    import gb5_pkg::*;
#(
    parameter int WIDTH = LINE_WORD_W,
    parameter int DEPTH = DEFAULT_MAX_WIDTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
